FILE: design/assert_macros.svh
// Assertion macros shared by the subpage frame pairing RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is low.
`define SPFP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds on a rising edge out of reset.
`define SPFP_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `SPFP_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

FILE: design/spfp_pkg.sv
// Types, constants and codes of the subpage frame pairing block.
`default_nettype none

package spfp_pkg;

    localparam int POS_W      = 10;
    localparam int WORD_W     = 32;
    localparam int TIME_W     = 32;
    localparam int AGE_W      = 16;
    localparam int STREAK_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int PIXELS_DEF  = 768;
    localparam int COLUMNS_DEF = 32;

    localparam logic [AGE_W-1:0]    MAX_AGE_RST   = 16'd80;
    localparam logic [AGE_W-1:0]    GRACE_AGE_RST = 16'd160;
    localparam logic [STREAK_W-1:0] STREAK_MAX    = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE_AGE = 1'b1;

    // pair status codes
    localparam logic [STATUS_W-1:0] ST_COMPOSED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GRACE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_WAITING  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EXPIRED  = 2'd3;

    typedef struct packed {
        logic              subpage_id;
        logic [POS_W-1:0]  pixel_position;
        logic [WORD_W-1:0] pixel_word;
        logic [TIME_W-1:0] capture_ms;
    } t_in_word;

    typedef struct packed {
        logic [POS_W-1:0]    out_position;
        logic [WORD_W-1:0]   out_word;
        logic                frame_end;
        logic [STATUS_W-1:0] pair_status;
        logic [TIME_W-1:0]   partner_gap_ms;
        logic [STREAK_W-1:0] same_streak;
        logic [TIME_W-1:0]   merged_ms;
    } t_out_word;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_store_ctl;

endpackage

`default_nettype wire

FILE: design/spfp_ram.sv
// Generic one-write, one-read RAM with registered read data.
`default_nettype none

module spfp_ram #(
    parameter int WIDTH = spfp_pkg::WORD_W,
    parameter int DEPTH = spfp_pkg::PIXELS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/spfp_decode.sv
// Input register, range check and checkerboard owner decode of the pixel position.
`default_nettype none

module spfp_decode #(
    parameter int PIXELS  = spfp_pkg::PIXELS_DEF,
    parameter int COLUMNS = spfp_pkg::COLUMNS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire spfp_pkg::t_in_word i_word,
    output logic                   o_valid,
    output spfp_pkg::t_in_word     o_word,
    output logic                   o_owner
);

    localparam int POS_W = spfp_pkg::POS_W;
    localparam int SH    = POS_W + 8;
    localparam int PW    = POS_W + SH;
    localparam int CMP_W = POS_W + 3;
    // floor reciprocal: the row estimate is exact or one low
    localparam logic [SH-1:0]    RECIP = SH'((1 << SH) / COLUMNS);
    localparam logic [POS_W-1:0] COLS  = POS_W'(COLUMNS);

    logic               r_s1_valid;
    spfp_pkg::t_in_word r_s1_word;
    logic               r_s2_valid;
    spfp_pkg::t_in_word r_s2_word;
    logic [POS_W-1:0]   r_s2_row;
    logic               r_s3_valid;
    spfp_pkg::t_in_word r_s3_word;
    logic               r_s3_owner;

    logic [PW-1:0]    prod;
    logic             in_range;
    logic [POS_W-1:0] row_cols;
    logic [POS_W-1:0] rem;
    logic             row_up;
    logic             n_owner;

    always_comb begin
        prod     = PW'(r_s1_word.pixel_position) * PW'(RECIP);
        in_range = CMP_W'(r_s1_word.pixel_position) < CMP_W'(PIXELS);
    end

    // fix the estimate: remainder stays below twice the column count
    always_comb begin
        row_cols = r_s2_row * COLS;
        rem      = r_s2_word.pixel_position - row_cols;
        row_up   = rem >= COLS;
        n_owner  = r_s2_row[0] ^ row_up ^ rem[0] ^ (row_up & COLS[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid && in_range;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_word  <= i_word;
            r_s2_word  <= r_s1_word;
            r_s2_row   <= prod[PW-1:SH];
            r_s3_word  <= r_s2_word;
            r_s3_owner <= n_owner;
        end
    end

    assign o_valid = r_s3_valid;
    assign o_word  = r_s3_word;
    assign o_owner = r_s3_owner;

endmodule

`default_nettype wire

FILE: design/spfp_frame.sv
// Frame control: subpage times, streak, pairing decision, store access and result register.
`default_nettype none

module spfp_frame #(
    parameter int PIXELS = spfp_pkg::PIXELS_DEF,
    localparam int ADDR_W = $clog2(PIXELS)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_pix_valid,
    input  wire spfp_pkg::t_in_word            i_pix,
    input  wire logic                          i_owner,
    input  wire logic [spfp_pkg::AGE_W-1:0]    i_max_age,
    input  wire logic [spfp_pkg::AGE_W-1:0]    i_grace_age,
    output spfp_pkg::t_store_ctl               o_store,
    output logic      [ADDR_W-1:0]             o_addr,
    output logic      [spfp_pkg::WORD_W-1:0]   o_wdata,
    output logic                               o_res_valid,
    output spfp_pkg::t_out_word                o_res,
    output logic                               o_res_from_store
);

    `include "assert_macros.svh"

    localparam int TIME_W   = spfp_pkg::TIME_W;
    localparam int STREAK_W = spfp_pkg::STREAK_W;
    localparam int STATUS_W = spfp_pkg::STATUS_W;
    localparam int CMP_W    = spfp_pkg::POS_W + 3;

    logic [TIME_W-1:0]   r_sp_time [2];
    logic [1:0]          r_sp_valid;
    logic                r_last_valid;
    logic                r_last_id;
    logic [STREAK_W-1:0] r_streak;
    logic [STATUS_W-1:0] r_mode;
    logic [TIME_W-1:0]   r_gap;
    logic [TIME_W-1:0]   r_time;
    logic                r_open;
    logic                r_res_valid;
    spfp_pkg::t_out_word r_res;
    logic                r_from_store;

    logic                is_first;
    logic                is_last;
    logic                sp_id;
    logic                other_valid;
    logic [TIME_W-1:0]   other_time;
    logic [TIME_W-1:0]   gap_raw;
    logic [STATUS_W-1:0] open_mode;
    logic [TIME_W-1:0]   open_gap;
    logic [TIME_W-1:0]   open_time;
    logic [STREAK_W-1:0] open_streak;
    logic                open_now;
    logic                frame_live;
    logic                sub;
    logic [STATUS_W-1:0] mode_c;
    logic [TIME_W-1:0]   gap_c;
    logic [TIME_W-1:0]   time_c;
    logic [STREAK_W-1:0] streak_c;
    logic                composes;
    logic                own;
    logic                active;
    spfp_pkg::t_store_ctl store;
    logic                n_res_valid;
    spfp_pkg::t_out_word n_res;

    // decision taken when pixel 0 opens a frame
    always_comb begin
        sp_id       = i_pix.subpage_id;
        other_valid = r_sp_valid[~sp_id];
        other_time  = r_sp_time[~sp_id];
        gap_raw     = i_pix.capture_ms - other_time;
        if (!other_valid) begin
            open_mode = spfp_pkg::ST_WAITING;
        end else if (gap_raw > TIME_W'(i_max_age)) begin
            open_mode = (gap_raw > TIME_W'(i_grace_age)) ? spfp_pkg::ST_EXPIRED
                                                         : spfp_pkg::ST_GRACE;
        end else begin
            open_mode = spfp_pkg::ST_COMPOSED;
        end
        open_gap = other_valid ? gap_raw : '0;
        if (open_mode == spfp_pkg::ST_COMPOSED || open_mode == spfp_pkg::ST_GRACE) begin
            open_time = (i_pix.capture_ms >= other_time) ? i_pix.capture_ms : other_time;
        end else begin
            open_time = '0;
        end
        if (r_last_valid && (r_last_id == sp_id)) begin
            open_streak = (r_streak == spfp_pkg::STREAK_MAX) ? r_streak
                                                            : r_streak + 16'd1;
        end else begin
            open_streak = 16'd1;
        end
    end

    always_comb begin
        is_first   = i_pix.pixel_position == '0;
        is_last    = CMP_W'(i_pix.pixel_position) == CMP_W'(PIXELS - 1);
        open_now   = i_pix_valid && is_first;
        frame_live = open_now || r_open;
        sub        = open_now ? sp_id : r_last_id;
        mode_c     = open_now ? open_mode : r_mode;
        gap_c      = open_now ? open_gap : r_gap;
        time_c     = open_now ? open_time : r_time;
        streak_c   = open_now ? open_streak : r_streak;
        composes   = (mode_c == spfp_pkg::ST_COMPOSED) || (mode_c == spfp_pkg::ST_GRACE);
        own        = i_owner == sub;
        active     = i_pix_valid && frame_live;

        store.wr = i_en && active && own;
        store.rd = i_en && active && composes && !own;

        n_res_valid = active && (composes || is_last);
        n_res.partner_gap_ms = gap_c;
        n_res.same_streak    = streak_c;
        n_res.pair_status    = mode_c;
        if (composes) begin
            n_res.out_position = i_pix.pixel_position;
            n_res.out_word     = i_pix.pixel_word;
            n_res.frame_end    = is_last;
            n_res.merged_ms    = time_c;
        end else begin
            n_res.out_position = '0;
            n_res.out_word     = '0;
            n_res.frame_end    = 1'b1;
            n_res.merged_ms    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp_time[0] <= '0;
            r_sp_time[1] <= '0;
            r_sp_valid   <= '0;
            r_last_valid <= 1'b0;
            r_last_id    <= 1'b0;
            r_streak     <= '0;
            r_mode       <= spfp_pkg::ST_COMPOSED;
            r_gap        <= '0;
            r_time       <= '0;
            r_open       <= 1'b0;
            r_res_valid  <= 1'b0;
        end else if (i_en) begin
            r_res_valid <= n_res_valid;
            if (i_pix_valid) begin
                r_open <= frame_live && !is_last;
            end
            if (open_now) begin
                r_sp_time[sp_id]  <= i_pix.capture_ms;
                r_sp_valid[sp_id] <= 1'b1;
                // drop a partner that is past the grace window
                if (open_mode == spfp_pkg::ST_EXPIRED) begin
                    r_sp_time[~sp_id]  <= '0;
                    r_sp_valid[~sp_id] <= 1'b0;
                end
                r_last_valid <= 1'b1;
                r_last_id    <= sp_id;
                r_streak     <= open_streak;
                r_mode       <= open_mode;
                r_gap        <= open_gap;
                r_time       <= open_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res        <= n_res;
            r_from_store <= store.rd;
        end
    end

    assign o_store          = store;
    assign o_addr           = ADDR_W'(i_pix.pixel_position);
    assign o_wdata          = i_pix.pixel_word;
    assign o_res_valid      = r_res_valid;
    assign o_res            = r_res;
    assign o_res_from_store = r_from_store;

    `SPFP_ASSERT(a_wait_ends_frame, i_clk, i_rst_n,
        r_res_valid && (r_res.pair_status == spfp_pkg::ST_WAITING ||
        r_res.pair_status == spfp_pkg::ST_EXPIRED) |-> r_res.frame_end,
        "waiting result without frame end")
    `SPFP_ASSERT(a_open_has_streak, i_clk, i_rst_n,
        r_open |-> (r_last_valid && r_streak != '0),
        "open frame without a subpage streak")
    `SPFP_ASSERT_NEVER(a_store_rd_wr, i_clk, i_rst_n,
        o_store.wr && o_store.rd, "store read and written for one pixel")

endmodule

`default_nettype wire

FILE: design/subpage_frame_pairing_top.sv
// Top level of the subpage frame pairing block: configuration, pixel store and output skid.
`default_nettype none

// Subpage frame pairing merges the two interleaved subpage frames of a thermal
// array into checkerboard frames, one pixel word in and at most one result word
// out per cycle. The block takes a new input word every cycle as long as
// o_in_stall is low; on its way out a result passes the input register, two
// stages of row/column owner decode, the frame control register loaded
// together with the pixel store read data, and the output register.
// The pixel store is a single RAM of PIXELS words with one write and one read
// port; a pixel writes the store when its own subpage owns its position, and a
// composed frame reads the partner subpage's pixels from it. The store is not
// cleared after reset: merging a frame before both subpages have delivered the
// positions they own returns whatever the RAM holds there. A frame that cannot
// pair gives one waiting or expired result at its last pixel; out-of-range
// positions and pixels outside an open frame give nothing. o_in_stall rises
// only when the output register is stalled and one more result sits in the skid
// register. The user writes max_age_ms and grace_age_ms via the write port only
// while idle; the block does not enforce it. Both are taken at the next pixel 0.
module subpage_frame_pairing_top #(
    parameter int PIXELS  = spfp_pkg::PIXELS_DEF,
    parameter int COLUMNS = spfp_pkg::COLUMNS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // pixel words in
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire spfp_pkg::t_in_word               i_in_word,
    // merged words out
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output spfp_pkg::t_out_word                   o_out_word,
    // configuration writes
    input  wire logic                             i_cfg_we,
    input  wire logic [spfp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [spfp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    `include "assert_macros.svh"

    localparam int ADDR_W = $clog2(PIXELS);
    localparam int AGE_W  = spfp_pkg::AGE_W;

    logic [AGE_W-1:0]     r_max_age;
    logic [AGE_W-1:0]     r_grace_age;
    logic                 r_out_valid;
    spfp_pkg::t_out_word  r_out;
    logic                 r_skid_valid;
    spfp_pkg::t_out_word  r_skid;

    logic                 en;
    logic                 pix_valid;
    spfp_pkg::t_in_word   pix;
    logic                 pix_owner;
    spfp_pkg::t_store_ctl store;
    logic [ADDR_W-1:0]    store_addr;
    logic [spfp_pkg::WORD_W-1:0] store_wdata;
    logic [spfp_pkg::WORD_W-1:0] store_rdata;
    logic                 res_valid;
    spfp_pkg::t_out_word  res_raw;
    logic                 res_from_store;
    spfp_pkg::t_out_word  res;
    logic                 take;
    logic                 push;

    // the whole pipeline advances unless the skid holds a word
    assign en         = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age   <= spfp_pkg::MAX_AGE_RST;
            r_grace_age <= spfp_pkg::GRACE_AGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                spfp_pkg::REG_MAX_AGE: begin
                    r_max_age <= AGE_W'(i_cfg_wdata);
                end
                spfp_pkg::REG_GRACE_AGE: begin
                    r_grace_age <= AGE_W'(i_cfg_wdata);
                end
                default: begin
                end
            endcase
        end
    end

    spfp_decode #(
        .PIXELS  (PIXELS),
        .COLUMNS (COLUMNS)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .o_valid (pix_valid),
        .o_word  (pix),
        .o_owner (pix_owner)
    );

    spfp_frame #(
        .PIXELS (PIXELS)
    ) u_frame (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_pix_valid      (pix_valid),
        .i_pix            (pix),
        .i_owner          (pix_owner),
        .i_max_age        (r_max_age),
        .i_grace_age      (r_grace_age),
        .o_store          (store),
        .o_addr           (store_addr),
        .o_wdata          (store_wdata),
        .o_res_valid      (res_valid),
        .o_res            (res_raw),
        .o_res_from_store (res_from_store)
    );

    spfp_ram #(
        .WIDTH (spfp_pkg::WORD_W),
        .DEPTH (PIXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store.wr),
        .i_waddr (store_addr),
        .i_wdata (store_wdata),
        .i_re    (store.rd),
        .i_raddr (store_addr),
        .o_rdata (store_rdata)
    );

    // take the partner pixel from the store where the frame control asked for it
    always_comb begin
        res = res_raw;
        if (res_from_store) begin
            res.out_word = store_rdata;
        end
    end

    assign take = r_out_valid && !i_out_stall;
    assign push = en && res_valid;

    // output register with one skid word behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_valid || take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `SPFP_ASSERT_NEVER(a_skid_alone, i_clk, i_rst_n,
        r_skid_valid && !r_out_valid, "skid word without an output word")
    `SPFP_ASSERT(a_skid_on_stall, i_clk, i_rst_n,
        $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall),
        "skid filled while the output register was free")

endmodule

`default_nettype wire

FILE: test/tb_subpage_frame_pairing_top.sv
// Self-checking testbench for subpage_frame_pairing_top: directed table, then random frames.
`timescale 1ns / 1ps

module tb_subpage_frame_pairing_top;

    localparam int N_PIX       = spfp_pkg::PIXELS_DEF;
    localparam int N_COLS      = spfp_pkg::COLUMNS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    // extra wait for the pipe to empty, with some margin
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_SETTING = 300;

    typedef enum logic [1:0] {
        ROW_NONE,     // no result may come from this word
        ROW_TYPED,    // result typed into the table
        ROW_PREDICT   // result taken from the frame predictor
    } t_row_kind;

    typedef struct packed {
        logic                        id;
        logic [spfp_pkg::POS_W-1:0]  pos;
        logic [spfp_pkg::WORD_W-1:0] word;
        logic [spfp_pkg::TIME_W-1:0] ms;
        t_row_kind                   kind;
        spfp_pkg::t_out_word         want;
    } t_dir_row;

    typedef struct packed {
        logic [spfp_pkg::AGE_W-1:0] late_ms;
        logic [spfp_pkg::AGE_W-1:0] drop_ms;
    } t_age_pair;

    // ------------------------------------------------------------------
    // Clock, reset and block ports; every input known from time zero
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    spfp_pkg::t_in_word              in_word   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    spfp_pkg::t_out_word             out_word;
    logic                            cfg_we    = 1'b0;
    logic [spfp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [spfp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    always #5 clk = ~clk;

    subpage_frame_pairing_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Frame predictor state: our own copy of the ages, store and timing
    // ------------------------------------------------------------------
    logic [spfp_pkg::AGE_W-1:0]    age_late = spfp_pkg::MAX_AGE_RST;
    logic [spfp_pkg::AGE_W-1:0]    age_drop = spfp_pkg::GRACE_AGE_RST;
    logic [spfp_pkg::WORD_W-1:0]   px_store   [N_PIX];
    bit                            px_written [N_PIX];
    logic [spfp_pkg::TIME_W-1:0]   sp_time  [2] = '{32'd0, 32'd0};
    logic                          sp_valid [2] = '{1'b0, 1'b0};
    logic [1:0]                    last_sub = 2'd3;
    logic [spfp_pkg::STREAK_W-1:0] streak   = '0;
    logic [spfp_pkg::STATUS_W-1:0] fr_mode  = spfp_pkg::ST_COMPOSED;
    logic [spfp_pkg::TIME_W-1:0]   fr_gap   = '0;
    logic [spfp_pkg::TIME_W-1:0]   fr_time  = '0;
    bit                            fr_open  = 1'b0;

    spfp_pkg::t_out_word pending_merges [$];
    int        mismatches    = 0;
    int        results_seen  = 0;
    int        pixels_framed = 0;
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    int        cycles        = 0;

    // Checkerboard owner of a position: row parity xor column parity.
    function automatic logic pos_owner(input logic [spfp_pkg::POS_W-1:0] pos);
        int row;
        int col;
        row = pos / N_COLS;
        col = pos % N_COLS;
        return row[0] ^ col[0];
    endfunction

    // A composed frame must never read a partner entry that was never written.
    function automatic bit store_ready(input logic [spfp_pkg::POS_W-1:0] pos);
        return !(fr_open && fr_mode <= spfp_pkg::ST_GRACE && pos_owner(pos) != last_sub[0]
                 && !px_written[pos]);
    endfunction

    // Pixel 0: bump the streak, stamp this subpage and grade the partner gap.
    task automatic open_frame(input logic id, input logic [spfp_pkg::TIME_W-1:0] now);
        logic                        other;
        logic [spfp_pkg::TIME_W-1:0] gap;
        other = ~id;
        gap   = '0;
        if (last_sub == {1'b0, id}) begin
            if (streak != spfp_pkg::STREAK_MAX)
                streak++;
        end else begin
            last_sub = {1'b0, id};
            streak   = 16'd1;
        end
        sp_time[id]  = now;
        sp_valid[id] = 1'b1;
        fr_mode      = spfp_pkg::ST_COMPOSED;
        if (sp_valid[other]) begin
            gap = now - sp_time[other];
            if (gap > age_late) begin
                if (gap <= age_drop) begin
                    fr_mode = spfp_pkg::ST_GRACE;
                end else begin
                    // partner too old: drop it and its time
                    sp_valid[other] = 1'b0;
                    sp_time[other]  = '0;
                    fr_mode         = spfp_pkg::ST_EXPIRED;
                end
            end
        end else begin
            fr_mode = spfp_pkg::ST_WAITING;
        end
        fr_gap  = gap;
        fr_time = '0;
        if (fr_mode <= spfp_pkg::ST_GRACE)
            fr_time = (sp_time[id] >= sp_time[other]) ? sp_time[id] : sp_time[other];
        fr_open = 1'b1;
    endtask

    // Predict the result of one accepted pixel word; used is set when the
    // word lands inside an open frame.
    task automatic merge_pixel(input spfp_pkg::t_in_word w, output bit has_res,
                               output spfp_pkg::t_out_word res, output bit used);
        logic [spfp_pkg::POS_W-1:0]  pos;
        logic [spfp_pkg::WORD_W-1:0] merged;
        logic                        sub;
        bit                          closing;
        has_res = 1'b0;
        res     = '0;
        used    = 1'b0;
        pos     = w.pixel_position;
        if (pos >= N_PIX)
            return;
        if (pos == 0)
            open_frame(w.subpage_id, w.capture_ms);
        if (!fr_open)
            return;
        used    = 1'b1;
        sub     = last_sub[0];
        closing = (pos == N_PIX - 1);
        merged  = px_store[pos];
        if (pos_owner(pos) == sub) begin
            px_store[pos]   = w.pixel_word;
            px_written[pos] = 1'b1;
            merged          = w.pixel_word;
        end
        if (fr_mode <= spfp_pkg::ST_GRACE) begin
            has_res = 1'b1;
            res     = '{pos, merged, closing, fr_mode, fr_gap, streak, fr_time};
        end else if (closing) begin
            has_res = 1'b1;
            res     = '{'0, '0, 1'b1, fr_mode, fr_gap, streak, '0};
        end
        if (closing)
            fr_open = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checking: one line per wrong field, run goes on
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("result %0d: %s got %h expected %h", results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk) begin
        spfp_pkg::t_out_word want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_merges.size() == 0) begin
                    report_mismatch("word with nothing pending, position",
                                    32'(out_word.out_position), '0);
                end else begin
                    want = pending_merges.pop_front();
                    if (out_word.out_position !== want.out_position)
                        report_mismatch("out_position", 32'(out_word.out_position),
                                        32'(want.out_position));
                    if (out_word.out_word !== want.out_word)
                        report_mismatch("out_word", out_word.out_word, want.out_word);
                    if (out_word.frame_end !== want.frame_end)
                        report_mismatch("frame_end", 32'(out_word.frame_end),
                                        32'(want.frame_end));
                    if (out_word.pair_status !== want.pair_status)
                        report_mismatch("pair_status", 32'(out_word.pair_status),
                                        32'(want.pair_status));
                    if (out_word.partner_gap_ms !== want.partner_gap_ms)
                        report_mismatch("partner_gap_ms", out_word.partner_gap_ms,
                                        want.partner_gap_ms);
                    if (out_word.same_streak !== want.same_streak)
                        report_mismatch("same_streak", 32'(out_word.same_streak),
                                        32'(want.same_streak));
                    if (out_word.merged_ms !== want.merged_ms)
                        report_mismatch("merged_ms", out_word.merged_ms, want.merged_ms);
                end
                results_seen++;
            end
            // stall the next cycle at the current receiver rate
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Hard stop on a hung handshake.
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still pending",
                     cycles, pending_merges.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one pixel word, idling at the sender rate, and predict it once taken.
    // Drop a word that would make a composed frame read a never-written entry.
    task automatic drive_pixel(input spfp_pkg::t_in_word w, input t_row_kind kind,
                               input spfp_pkg::t_out_word typed);
        spfp_pkg::t_out_word res;
        bit                  has_res;
        bit                  used;
        if (w.pixel_position != 0 && w.pixel_position < N_PIX
            && !store_ready(w.pixel_position))
            return;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        // hold the word until the block takes it
        do @(posedge clk); while (in_stall);
        merge_pixel(w, has_res, res, used);
        if (kind == ROW_TYPED)
            pending_merges.push_back(typed);
        else if (kind == ROW_PREDICT && has_res)
            pending_merges.push_back(res);
        if (used)
            pixels_framed++;
    endtask

    function automatic spfp_pkg::t_in_word rand_pixel(input int pos);
        spfp_pkg::t_in_word w;
        w.subpage_id     = 1'($urandom_range(0, 1));
        w.pixel_position = spfp_pkg::POS_W'(pos);
        w.pixel_word     = $urandom;
        w.capture_ms     = $urandom;
        return w;
    endfunction

    // Capture time aimed at a gap class: fresh, grace window, dropped, wild, or
    // right on a boundary. Sums wrap at 32 bits on purpose.
    function automatic logic [spfp_pkg::TIME_W-1:0] pick_ms(input logic id);
        logic [spfp_pkg::TIME_W-1:0] base;
        logic [spfp_pkg::TIME_W-1:0] d;
        logic [spfp_pkg::TIME_W-1:0] lo;
        base = sp_valid[~id] ? sp_time[~id] : $urandom;
        lo   = 32'(age_late) + 32'd1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: d = $urandom_range(0, age_late);
            5, 6:          d = (age_drop > age_late) ? $urandom_range(lo, age_drop) : lo;
            7:             d = 32'(age_drop) + 32'd1 + $urandom_range(0, 500);
            8:             d = $urandom;
            default: begin
                case ($urandom_range(0, 3))
                    0:       d = 32'(age_late);
                    1:       d = lo;
                    2:       d = 32'(age_drop);
                    default: d = 32'(age_drop) + 32'd1;
                endcase
            end
        endcase
        return base + d;
    endfunction

    function automatic spfp_pkg::t_in_word opener(input logic id);
        spfp_pkg::t_in_word w;
        w            = rand_pixel(0);
        w.subpage_id = id;
        w.capture_ms = pick_ms(id);
        return w;
    endfunction

    // One short frame: pixel 0, a few scattered pixels with some noise
    // (out-of-range positions, repeated pixel 0), mostly closed at the last pixel.
    task automatic send_frame();
        spfp_pkg::t_in_word w;
        logic               id;
        int                 r;
        id = ($urandom_range(0, 9) < 7) ? ~last_sub[0] : last_sub[0];
        drive_pixel(opener(id), ROW_PREDICT, '0);
        repeat ($urandom_range(0, 12)) begin
            w = rand_pixel($urandom_range(1, N_PIX - 2));
            r = $urandom_range(0, 99);
            if (r < 8)
                w.pixel_position = spfp_pkg::POS_W'($urandom_range(N_PIX, 1023));
            else if (r < 11)
                w = opener(1'($urandom_range(0, 1)));
            drive_pixel(w, ROW_PREDICT, '0);
        end
        if ($urandom_range(0, 9) != 0)
            drive_pixel(rand_pixel(N_PIX - 1), ROW_PREDICT, '0);
        // stray word, usually outside any frame
        if ($urandom_range(0, 9) == 0)
            drive_pixel(rand_pixel($urandom_range(1, 1023)), ROW_PREDICT, '0);
    endtask

    // Drop valid, wait for every pending word, then let the pipe empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_merges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both ages through the config port; each write updates one register.
    task automatic set_ages(input logic [spfp_pkg::AGE_W-1:0] late_ms,
                            input logic [spfp_pkg::AGE_W-1:0] drop_ms);
        cfg_we    <= 1'b1;
        cfg_index <= spfp_pkg::REG_MAX_AGE;
        cfg_wdata <= late_ms;
        @(posedge clk);
        cfg_index <= spfp_pkg::REG_GRACE_AGE;
        cfg_wdata <= drop_ms;
        @(posedge clk);
        cfg_we   <= 1'b0;
        age_late = late_ms;
        age_drop = drop_ms;
    endtask

    // Directed rows under reset ages (80 late, 160 dropped).
    t_dir_row dir_rows [22] = '{
        // stray word before any frame, lone subpage 0 frame, out-of-range word
        '{1'b0, 10'd5,    32'h1111_1111, 32'd0,    ROW_NONE, '0},
        '{1'b0, 10'd0,    32'hFFFF_FFFF, 32'd1000, ROW_NONE, '0},
        '{1'b1, 10'd1000, 32'h2222_2222, 32'd0,    ROW_NONE, '0},
        '{1'b1, 10'd767,  32'h0000_0000, 32'd5,    ROW_TYPED,
          '{10'd0, 32'h0, 1'b1, spfp_pkg::ST_WAITING, 32'd0, 16'd1, 32'd0}},
        // subpage 1 pairs 50 ms later; id and time ignored after pixel 0
        '{1'b1, 10'd0,    32'h3333_3333, 32'd1050, ROW_TYPED,
          '{10'd0, 32'hFFFF_FFFF, 1'b0, spfp_pkg::ST_COMPOSED, 32'd50, 16'd1, 32'd1050}},
        '{1'b0, 10'd1,    32'hDEAD_BEEF, 32'd9,    ROW_TYPED,
          '{10'd1, 32'hDEAD_BEEF, 1'b0, spfp_pkg::ST_COMPOSED, 32'd50, 16'd1, 32'd1050}},
        '{1'b0, 10'd767,  32'h4444_4444, 32'd0,    ROW_TYPED,
          '{10'd767, 32'h0, 1'b1, spfp_pkg::ST_COMPOSED, 32'd50, 16'd1, 32'd1050}},
        // same subpage again, 150 ms after its partner: late but in grace
        '{1'b1, 10'd0,    32'h5555_5555, 32'd1150, ROW_TYPED,
          '{10'd0, 32'hFFFF_FFFF, 1'b0, spfp_pkg::ST_GRACE, 32'd150, 16'd2, 32'd1150}},
        '{1'b1, 10'd767,  32'h6666_6666, 32'd0,    ROW_TYPED,
          '{10'd767, 32'h0, 1'b1, spfp_pkg::ST_GRACE, 32'd150, 16'd2, 32'd1150}},
        // 200 ms gap drops the partner; repeated pixel 0 with a wild time
        '{1'b0, 10'd0,    32'h0000_0000, 32'd1350, ROW_NONE, '0},
        '{1'b1, 10'd0,    32'h7777_7777, 32'hFFFF_FFF0, ROW_NONE, '0},
        '{1'b0, 10'd767,  32'h8888_8888, 32'd0,    ROW_TYPED,
          '{10'd0, 32'h0, 1'b1, spfp_pkg::ST_EXPIRED, 32'hFFFF_FAAA, 16'd1, 32'd0}},
        // time wraps past zero: gap 48, older stamp is the larger raw value
        '{1'b0, 10'd0,    32'h9999_9999, 32'h20,   ROW_TYPED,
          '{10'd0, 32'h9999_9999, 1'b0, spfp_pkg::ST_COMPOSED, 32'd48, 16'd1,
            32'hFFFF_FFF0}},
        '{1'b1, 10'd2,    32'hAAAA_AAAA, 32'hFFFF_FFFF, ROW_PREDICT, '0},
        '{1'b1, 10'd33,   32'hBBBB_BBBB, 32'd0,    ROW_PREDICT, '0},
        '{1'b0, 10'd767,  32'hCCCC_CCCC, 32'd0,    ROW_PREDICT, '0},
        // gaps of exactly 80, 81, 160 and 161 ms against subpage 1
        '{1'b0, 10'd0,    32'h1234_5678, 32'h40,   ROW_PREDICT, '0},
        '{1'b0, 10'd767,  32'h8765_4321, 32'd0,    ROW_PREDICT, '0},
        '{1'b0, 10'd0,    32'h0F0F_0F0F, 32'h41,   ROW_PREDICT, '0},
        '{1'b0, 10'd0,    32'hF0F0_F0F0, 32'h90,   ROW_PREDICT, '0},
        '{1'b0, 10'd0,    32'h5A5A_5A5A, 32'h91,   ROW_NONE, '0},
        '{1'b0, 10'd767,  32'hA5A5_A5A5, 32'd0,    ROW_TYPED,
          '{10'd0, 32'h0, 1'b1, spfp_pkg::ST_EXPIRED, 32'd161, 16'd5, 32'd0}}
    };

    // Age settings walked by the random part, extremes and inverted windows included.
    t_age_pair age_plan [6] = '{
        '{16'd80,    16'd160},
        '{16'd0,     16'd0},
        '{16'd65535, 16'd65535},
        '{16'd0,     16'd65535},
        '{16'd100,   16'd40},
        '{16'd65535, 16'd0}
    };

    initial begin
        int goal;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, sender idling lightly, receiver heavily
        send_idle_pct = 21;
        stall_pct     = 78;
        foreach (dir_rows[i])
            drive_pixel('{dir_rows[i].id, dir_rows[i].pos, dir_rows[i].word,
                          dir_rows[i].ms}, dir_rows[i].kind, dir_rows[i].want);

        // random frames: two age settings per idling phase
        foreach (age_plan[s]) begin
            settle();
            set_ages(age_plan[s].late_ms, age_plan[s].drop_ms);
            case (s / 2)
                0: begin
                    send_idle_pct = 21;
                    stall_pct     = 78;
                end
                1: begin
                    send_idle_pct = 78;
                    stall_pct     = 21;
                end
                default: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            goal = pixels_framed + ITEMS_PER_SETTING;
            while (pixels_framed < goal)
                send_frame();
        end

        settle();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
